@@ rtl/wmv_pkg.sv @@
`default_nettype none

package wmv_pkg;

  // item field widths
  localparam int unsigned CH_W      = 2;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned MEAN_W    = 20;
  localparam int unsigned VAR_W     = 30;
  localparam int unsigned FRAC_BITS = 8;

  // packed tdata widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 72;
  localparam int unsigned M_PAD_W  = M_DATA_W - (SAMPLE_W + FILL_W + MEAN_W + VAR_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDST,
    ST_RDRING,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ rtl/wmv_ram.sv @@
`default_nettype none

module wmv_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 60
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/wmv_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle while busy.
module wmv_div #(
  parameter int unsigned DW = 42,
  parameter int unsigned VW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic      [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/windowed_mean_variance_core.sv @@
`default_nettype none

// Channel   Dir  tdata (low bit up)                               tuser
// s_axis    in   sample[11:0]                                     channel[1:0]
// m_axis    out  latest_value, fill_count, mean_fixed,            source_channel[1:0]
//                variance_fixed
//
// One item at a time; of the two dividers the wider variance divider finishes last.
// A sample with channel >= CHANNELS is taken and dropped. After reset all windows
// are empty; no clearing pass. A result waiting on m_axis does not block the next
// input item; only the next result waits for it.
module windowed_mean_variance_core #(
  parameter int unsigned WINDOW   = 20,
  parameter int unsigned CHANNELS = 3
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [wmv_pkg::S_DATA_W-1:0]   s_axis_tdata_i,  // sample[11:0], zero pad
  input  wire logic [wmv_pkg::CH_W-1:0]       s_axis_tuser_i,  // channel
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // latest_value[11:0], fill_count[16:12], mean_fixed[36:17], variance_fixed[66:37], pad
  output logic      [wmv_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  output logic      [wmv_pkg::CH_W-1:0]       m_axis_tuser_o   // source_channel
);

  import wmv_pkg::*;

  localparam int unsigned CAW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RDEPTH = CHANNELS * WINDOW;
  localparam int unsigned RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int unsigned PW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NW     = $clog2(WINDOW + 1);
  localparam int unsigned SUMW   = $clog2(4095 * WINDOW + 1);
  localparam int unsigned SQW    = $clog2(4095 * 4095 * WINDOW + 1);
  localparam int unsigned SSW    = 2 * SAMPLE_W;
  localparam int unsigned NUMW   = NW + SQW;
  localparam int unsigned S2W    = 2 * SUMW;
  localparam int unsigned XW     = (NUMW > S2W) ? NUMW : S2W;
  localparam int unsigned MDW    = SUMW + FRAC_BITS;
  localparam int unsigned VDW    = NUMW + FRAC_BITS;
  localparam int unsigned NNW    = 2 * NW;

  typedef struct packed {
    logic [SQW-1:0]  sq;
    logic [SUMW-1:0] sum;
    logic [NW-1:0]   held;
    logic [PW-1:0]   pos;
  } chst_t;

  localparam int unsigned STW = $bits(chst_t);

  state_e state_q, state_d;

  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic [SSW-1:0]      ssq_q;
  chst_t               cur_q;
  logic [RAW-1:0]      slot_q;
  logic [NW-1:0]       n_q;
  logic [SUMW-1:0]     sum_q;
  logic [SQW-1:0]      sq_q;
  logic [NUMW-1:0]     nsq_q;
  logic [S2W-1:0]      sum2_q;
  logic [NNW-1:0]      nn_q;
  logic [CHANNELS-1:0] vld_q;
  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;
  logic [CH_W-1:0]     m_user_q;

  logic                in_acc;
  logic                ch_ok;
  logic [CAW-1:0]      in_idx;
  logic [CAW-1:0]      ch_idx;

  logic                st_we;
  logic                st_re;
  chst_t               st_wdata;
  logic [STW-1:0]      st_rdata;
  logic                ring_we;
  logic                ring_re;
  logic [RAW-1:0]      ring_raddr;
  logic [SAMPLE_W-1:0] ring_rdata;

  chst_t               cur;
  chst_t               upd;
  logic                full;
  logic [SSW-1:0]      old_sq;
  logic [XW-1:0]       num;
  logic                div_start;
  logic                mdiv_busy;
  logic                vdiv_busy;
  logic [MDW-1:0]      mdiv_q;
  logic [VDW-1:0]      vdiv_q;
  logic                out_load;

  assign in_idx = CAW'(s_axis_tuser_i);
  assign ch_idx = CAW'(ch_q);
  assign ch_ok  = (32'(s_axis_tuser_i) < 32'(CHANNELS));
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && ch_ok) state_d = ST_RDST;
      ST_RDST:   state_d = ST_RDRING;
      ST_RDRING: state_d = ST_MUL;
      ST_MUL:    state_d = ST_SUB;
      ST_SUB:    state_d = ST_DIV;
      ST_DIV:    if (!mdiv_busy && !vdiv_busy) state_d = ST_DONE;
      ST_DONE:   if (!m_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // memory controls and datapath
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    st_re      = in_acc && ch_ok;
    ring_re    = (state_q == ST_RDST);
    ring_we    = (state_q == ST_RDRING);
    st_we      = (state_q == ST_RDRING);
    div_start  = (state_q == ST_SUB);
    out_load   = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

    // a channel not yet written reads as an empty window
    cur        = vld_q[ch_idx] ? chst_t'(st_rdata) : '0;
    ring_raddr = RAW'(ch_q) * RAW'(WINDOW) + RAW'(cur.pos);

    // oldest sample leaves only once the window is full
    full       = (cur_q.held == NW'(WINDOW));
    old_sq     = ring_rdata * ring_rdata;
    upd.pos    = (cur_q.pos == PW'(WINDOW - 1)) ? '0 : cur_q.pos + 1'b1;
    upd.held   = full ? cur_q.held : cur_q.held + 1'b1;
    upd.sum    = cur_q.sum + SUMW'(smp_q) - (full ? SUMW'(ring_rdata) : '0);
    upd.sq     = cur_q.sq + SQW'(ssq_q) - (full ? SQW'(old_sq) : '0);
    st_wdata   = upd;

    num = (XW'(nsq_q) >= XW'(sum2_q)) ? XW'(nsq_q) - XW'(sum2_q) : '0;
  end

  wmv_ram #(
    .WIDTH (STW),
    .DEPTH (CHANNELS)
  ) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (ch_idx),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (in_idx),
    .rdata_o (st_rdata)
  );

  wmv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RDEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot_q),
    .wdata_i (smp_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  wmv_div #(
    .DW (MDW),
    .VW (NW)
  ) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q, FRAC_BITS'(0)}),
    .divisor_i  (n_q),
    .busy_o     (mdiv_busy),
    .quotient_o (mdiv_q)
  );

  wmv_div #(
    .DW (VDW),
    .VW (NNW)
  ) u_var_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({NUMW'(num), FRAC_BITS'(0)}),
    .divisor_i  (nn_q),
    .busy_o     (vdiv_busy),
    .quotient_o (vdiv_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (st_we) begin
        vld_q[ch_idx] <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= s_axis_tuser_i;
      smp_q <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (state_q == ST_RDST) begin
      cur_q  <= cur;
      slot_q <= ring_raddr;
      ssq_q  <= smp_q * smp_q;
    end
    if (state_q == ST_RDRING) begin
      n_q   <= upd.held;
      sum_q <= upd.sum;
      sq_q  <= upd.sq;
    end
    if (state_q == ST_MUL) begin
      nsq_q  <= n_q * sq_q;
      sum2_q <= sum_q * sum_q;
      nn_q   <= n_q * n_q;
    end
    if (out_load) begin
      m_user_q <= ch_q;
      m_data_q <= {M_PAD_W'(0), VAR_W'(vdiv_q), MEAN_W'(mdiv_q), FILL_W'(n_q), smp_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // n*sumsq never falls below sum^2
  a_var_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB) |-> (XW'(nsq_q) >= XW'(sum2_q)))
    else $error("negative variance numerator");

  // fill count stays in 1..WINDOW on every write-back
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (upd.held != '0) && (upd.held <= NW'(WINDOW)))
    else $error("fill count out of range");

  a_ring_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (32'(slot_q) < 32'(RDEPTH)))
    else $error("ring write beyond depth");

  // dividers are done whenever a new item can enter
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mdiv_busy && !vdiv_busy))
    else $error("divider busy while idle");

endmodule

`default_nettype wire
